>>> rtl/tlpt_pkg.sv
// Shared types and constants of the two-level page table unit.
`default_nettype none
package tlpt_pkg;

   localparam int TABLE_ENTRIES  = 1024;
   localparam int TAB_AW         = 10;
   localparam int OFFSET_W       = 12;
   localparam int FRAME_W        = 20;
   localparam int SPACE_W        = 2;
   localparam int DIR_IDX_MAX_W  = 16;

   localparam logic MODE_TRANSLATE = 1'b0;
   localparam logic MODE_MAP       = 1'b1;

   localparam logic [1:0] OP_FAULT     = 2'd0;
   localparam logic [1:0] OP_TRANSLATE = 2'd1;
   localparam logic [1:0] OP_MAP       = 2'd2;

   localparam logic [31:0]         ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [OFFSET_W-1:0] ENTRY_FLAGS = 12'h007;

   typedef struct packed {
      logic        mode;
      logic [31:0] virtual_address;
      logic [31:0] physical_address;
   } tlpt_req_type;

   typedef struct packed {
      logic [31:0] value;
      logic        fault;
   } tlpt_rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]               op;
      logic [DIR_IDX_MAX_W-1:0] dir;
      logic [TAB_AW-1:0]        tab;
      logic [OFFSET_W-1:0]      offset;
      logic [FRAME_W-1:0]       frame;
   } tlpt_cmd_type;

endpackage
`default_nettype wire

>>> rtl/tlpt_front.sv
// Front end: address space register, request accept and classification.
`default_nettype none
module tlpt_front #(
   parameter int ADDRESS_SPACES = 4,
   parameter int DIR_ENTRIES    = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tlpt_pkg::SPACE_W-1:0]  csr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire tlpt_pkg::tlpt_req_type        req_data,
   input  wire logic                          blocked,
   input  wire logic                          q_full,
   output logic                               push,
   output tlpt_pkg::tlpt_cmd_type             cmd
);

   logic [tlpt_pkg::SPACE_W-1:0] space_ff, space_in;
   logic [9:0]                   dir;
   logic                         in_range;

   assign csr_ready = 1'b1;

   always_comb begin
      space_in = space_ff;
      if (csr_valid) begin
         space_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         space_ff <= '0;
      end else begin
         space_ff <= space_in;
      end
   end

   assign req_ready = !blocked && !q_full;
   assign push      = req_valid && req_ready;

   assign dir      = req_data.virtual_address[31:22];
   assign in_range = (32'(space_ff) < ADDRESS_SPACES) && (32'(dir) < DIR_ENTRIES);

   always_comb begin
      cmd.dir    = tlpt_pkg::DIR_IDX_MAX_W'(32'(space_ff) * DIR_ENTRIES + 32'(dir));
      cmd.tab    = req_data.virtual_address[21:12];
      cmd.offset = req_data.virtual_address[11:0];
      cmd.frame  = req_data.physical_address[31:12];
      if (!in_range) begin
         cmd.op = tlpt_pkg::OP_FAULT;
      end else if (req_data.mode == tlpt_pkg::MODE_MAP) begin
         cmd.op = tlpt_pkg::OP_MAP;
      end else begin
         cmd.op = tlpt_pkg::OP_TRANSLATE;
      end
   end

endmodule
`default_nettype wire

>>> rtl/tlpt_queue.sv
// Two-entry command queue between front and back.
`default_nettype none
module tlpt_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire tlpt_pkg::tlpt_cmd_type push_data,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        q_valid,
   output tlpt_pkg::tlpt_cmd_type      q_data
);

   tlpt_pkg::tlpt_cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/tlpt_back.sv
// Back end: clearing pass, directory and frame memories, response register.
`default_nettype none
module tlpt_back #(
   parameter int ADDRESS_SPACES = 4,
   parameter int DIR_ENTRIES    = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire tlpt_pkg::tlpt_cmd_type q_data,
   output logic                        pop,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output tlpt_pkg::tlpt_rsp_type      rsp_data
);

   localparam int DIR_DEPTH = ADDRESS_SPACES * DIR_ENTRIES;
   localparam int PF_DEPTH  = DIR_DEPTH * tlpt_pkg::TABLE_ENTRIES;
   localparam int DIR_AW    = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
   localparam int PF_AW     = $clog2(PF_DEPTH);

   logic                          dir_mem [DIR_DEPTH];
   logic [tlpt_pkg::FRAME_W-1:0]  pf_mem  [PF_DEPTH];

   logic                          clear_ff, clear_in;
   logic [PF_AW-1:0]              clear_addr_ff, clear_addr_in;
   logic                          busy_ff, busy_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tlpt_pkg::tlpt_rsp_type        rsp_ff, rsp_in;
   tlpt_pkg::tlpt_cmd_type        hold_ff;
   logic                          dir_rd_ff;
   logic [tlpt_pkg::FRAME_W-1:0]  pf_rd_ff;

   logic [DIR_AW-1:0]             d;
   logic [PF_AW-1:0]              p;
   logic                          clear_dir;
   logic                          clear_last;

   assign d = q_data.dir[DIR_AW-1:0];
   assign p = PF_AW'({d, q_data.tab});

   assign clear_dir  = (clear_addr_ff < PF_AW'(DIR_DEPTH));
   assign clear_last = (clear_addr_ff == PF_AW'(PF_DEPTH - 1));

   assign clearing  = clear_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pop       = q_valid && !clear_ff && !busy_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + PF_AW'(1);
         if (clear_last) begin
            clear_in = 1'b0;
         end
      end
   end

   always_comb begin
      busy_in      = pop;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (busy_ff) begin
         rsp_valid_in = 1'b1;
         case (hold_ff.op)
            tlpt_pkg::OP_MAP: begin
               rsp_in.value = {hold_ff.frame, tlpt_pkg::ENTRY_FLAGS};
               rsp_in.fault = 1'b0;
            end
            tlpt_pkg::OP_TRANSLATE: begin
               if (dir_rd_ff) begin
                  rsp_in.value = {pf_rd_ff, hold_ff.offset};
                  rsp_in.fault = 1'b0;
               end else begin
                  rsp_in.value = tlpt_pkg::ALL_ONES;
                  rsp_in.fault = 1'b1;
               end
            end
            default: begin
               rsp_in.value = tlpt_pkg::ALL_ONES;
               rsp_in.fault = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (pop) begin
         hold_ff <= q_data;
      end
   end

   // each cycle: a clearing write or a map write, plus the read of both memories
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         pf_mem[clear_addr_ff] <= '0;
         if (clear_dir) begin
            dir_mem[clear_addr_ff[DIR_AW-1:0]] <= 1'b0;
         end
      end else if (pop && (q_data.op == tlpt_pkg::OP_MAP)) begin
         dir_mem[d] <= 1'b1;
         pf_mem[p]  <= q_data.frame;
      end
      dir_rd_ff <= dir_mem[d];
      pf_rd_ff  <= pf_mem[p];
   end

endmodule
`default_nettype wire

>>> rtl/two_level_page_table_translate_map.sv
// Top level of the two-level page table translate/map unit.
// Two-level page table with 4 KiB pages over 32-bit virtual addresses. A
// request either translates a virtual address (directory bits 31..22, table
// bits 21..12, offset bits 11..0) or maps a virtual page onto the frame in
// physical_address[31:12], in the address space held in the csr register.
// Translate returns frame:offset when the directory entry is present (the page
// entry itself is not checked, so an unwritten entry gives frame 0); a missing
// directory entry, a directory index at or beyond DIR_ENTRIES, or an address
// space at or beyond ADDRESS_SPACES returns all ones with fault set, and map
// does nothing in the out-of-range cases. A good map returns frame<<12 | 7.
// Timing: after reset a clearing pass zeroes the frame memory and directory
// bits one entry per cycle, and req_ready stays low until it ends; csr writes
// are taken at any time. After that a request passes in the back end through
// the single memory access (read of directory bit and page frame, or their
// write on map), registered together with the command, and then the forming
// of the response in the output register. No new request is popped while one
// is in its memory access or while a response waits on rsp_ready. The front
// accepts into a two-entry queue, so it keeps taking requests until it is full.
`default_nettype none
module two_level_page_table_translate_map #(
   parameter int ADDRESS_SPACES = 4,
   parameter int DIR_ENTRIES    = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // address space register
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tlpt_pkg::SPACE_W-1:0]  csr_data,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire tlpt_pkg::tlpt_req_type        req_data,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output tlpt_pkg::tlpt_rsp_type             rsp_data
);

   tlpt_pkg::tlpt_cmd_type push_cmd;
   tlpt_pkg::tlpt_cmd_type q_data;
   logic                   push;
   logic                   q_full;
   logic                   q_valid;
   logic                   pop;
   logic                   clearing;

   // classify requests: range check, op code, flat memory indexes
   tlpt_front #(
      .ADDRESS_SPACES (ADDRESS_SPACES),
      .DIR_ENTRIES    (DIR_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .blocked   (clearing),
      .q_full    (q_full),
      .push      (push),
      .cmd       (push_cmd)
   );

   // decouples accept from memory access
   tlpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   // memories, clearing pass and response register
   tlpt_back #(
      .ADDRESS_SPACES (ADDRESS_SPACES),
      .DIR_ENTRIES    (DIR_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/tlpt_checker.sv
// Port-level checker for the page table unit, bound to the top level.
`default_nettype none
module tlpt_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire tlpt_pkg::tlpt_rsp_type        rsp_data
);

   // a stalled response holds
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a fault always carries all ones
   fault_value_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |-> rsp_data.value == tlpt_pkg::ALL_ONES)
      else $error("fault response without all-ones value");

   // clearing pass starts at reset, so no request is taken right after it
   clear_block_a: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // no response survives reset
   rsp_reset_a: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind two_level_page_table_translate_map tlpt_checker u_checker (.*);
`default_nettype wire
